// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the mixer biquad block.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication under an active-low reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication under an active-low reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== sv/mbl_pkg.sv =====
`timescale 1ns / 1ps
// Shared types for the mixer biquad block: accumulator opcodes, the control
// group of the multiply-accumulate unit and the register indexes. No dependencies.
package mbl_pkg;

    localparam int NUM_REGS = 5;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_SUB
    } mbl_acc_op_t;

    typedef struct packed {
        logic        mul_en;
        mbl_acc_op_t acc_op;
    } mbl_mac_ctrl_t;

    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } mbl_reg_idx_t;

endpackage

// ===== sv/mbl_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sample input and the result output.
// Standalone; widths follow the SAMPLE_WIDTH parameter.
interface mbl_in_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] signal_sample;
    logic signed [SAMPLE_WIDTH-1:0] reference_sample;

    modport source (output valid, output signal_sample, output reference_sample,
                    input ready);
    modport sink   (input valid, input signal_sample, input reference_sample,
                    output ready);
endinterface

interface mbl_out_if #(parameter int SAMPLE_WIDTH = 16);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] mixed_product;
    logic signed [SAMPLE_WIDTH-1:0] filtered_sample;

    modport source (output valid, output mixed_product, output filtered_sample,
                    input ready);
    modport sink   (input valid, input mixed_product, input filtered_sample,
                    output ready);
endinterface

// ===== sv/mbl_mac.sv =====
`timescale 1ns / 1ps
// Shared signed multiplier with a registered product and a wrapping accumulator.
// Depends on mbl_pkg for the control group and accumulator opcodes.
module mbl_mac
    import mbl_pkg::*;
#(
    parameter int OPA_W   = 32,
    parameter int OPB_W   = 16,
    parameter int ACC_W   = 51,
    parameter int RND_POS = 28
)
(
    input  logic                            clk,
    input  mbl_mac_ctrl_t                   ctrl,
    input  logic signed [OPA_W-1:0]         opa,
    input  logic signed [OPB_W-1:0]         opb,
    output logic signed [OPA_W+OPB_W-1:0]   mul_q,
    output logic signed [ACC_W-1:0]         acc_q
);

    localparam int PROD_W = OPA_W + OPB_W;
    localparam int EXT_W  = (PROD_W > ACC_W) ? PROD_W : ACC_W;
    localparam logic [ACC_W-1:0] BIAS = ACC_W'(1) << RND_POS;

    logic signed [PROD_W-1:0] mul_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;
    logic signed [EXT_W-1:0]  mul_ext;
    logic signed [ACC_W-1:0]  mul_term;

    assign mul_ext  = EXT_W'(mul_reg);
    assign mul_term = signed'(mul_ext[ACC_W-1:0]);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD: acc_next = signed'(BIAS) + mul_term;
            ACC_ADD:  acc_next = acc_reg + mul_term;
            ACC_SUB:  acc_next = acc_reg - mul_term;
            default:  acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            mul_reg <= opa * opb;
        end
        acc_reg <= acc_next;
    end

    assign mul_q = mul_reg;
    assign acc_q = acc_reg;

endmodule

// ===== sv/mixer_biquad_lowpass.sv =====
`timescale 1ns / 1ps
// Top level of the mixer biquad block: APB coefficient registers, sequencer
// and history. Depends on mbl_pkg, mbl_ifs, mbl_mac and assert_macros.svh.
//
// Usage:
// sample_ch (sink) takes one item of signal_sample and reference_sample; the
// two are multiplied, shifted down to Q15 and saturated, then run through a
// direct form I biquad whose five Q2.29 coefficients sit on the APB port
// (b0, b1, b2, a1, a2 at byte offsets 0, 4, 8, 12, 16; 8-byte stride when
// COEF_WIDTH exceeds 32). result_ch (source) returns mixed_product and
// filtered_sample, one item per input item.
// Timing: one shared multiplier runs six products per item (mix, b1, b2, a1,
// a2, b0) under an eight-state sequencer that steps from acceptance through
// S_SAT, S_B2, S_A1, S_A2, S_B0, S_ADD and S_OUT, where the result is
// registered; sample_ch.ready is high only while the sequencer is idle.
// The result sits in an output register, so the next item is accepted while
// the previous result waits. If result_ch is stalled when a new result is
// ready, the sequencer holds in its last state until the register frees.
// Reset clears the coefficients, the product and output history and the
// output valid flag. Write coefficients only while the block is idle.
module mixer_biquad_lowpass
    import mbl_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 16,
    parameter int COEF_WIDTH   = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    mbl_in_if.sink              sample_ch,
    mbl_out_if.source           result_ch,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [((COEF_WIDTH > 32) ? 3 : 2) + 2:0] paddr,
    input  logic [((COEF_WIDTH > 32) ? 64 : 32) - 1:0] pwdata,
    output logic [((COEF_WIDTH > 32) ? 64 : 32) - 1:0] prdata,
    output logic                pready
);

`include "assert_macros.svh"

    localparam int SW         = SAMPLE_WIDTH;
    localparam int CW         = COEF_WIDTH;
    localparam int DATA_W     = (CW > 32) ? 64 : 32;
    localparam int STRIDE_LOG = (CW > 32) ? 3 : 2;
    localparam int ADDR_W     = STRIDE_LOG + 3;
    localparam int OPA_W      = (CW > SW) ? CW : SW;
    localparam int PROD_W     = OPA_W + SW;
    localparam int COEF_FRAC  = CW - 3;
    localparam int ACC_FULL   = CW + SW + 3;
    localparam int ACC_W      = (ACC_FULL > 64) ? 64 : ACC_FULL;
    localparam int Y_W        = (ACC_W > COEF_FRAC + SW) ? ACC_W : COEF_FRAC + SW;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SAT,
        S_B2,
        S_A1,
        S_A2,
        S_B0,
        S_ADD,
        S_OUT
    } state_t;

    // coefficient registers
    logic signed [CW-1:0] coef_b0_reg, coef_b1_reg, coef_b2_reg, coef_a1_reg, coef_a2_reg;
    logic                 cfg_wr;
    mbl_reg_idx_t         cfg_idx;

    // sequencer, history and output registers
    state_t               state_reg, state_next;
    logic signed [SW-1:0] p_reg, p_next;
    logic signed [SW-1:0] product_hist1_reg, product_hist1_next;
    logic signed [SW-1:0] product_hist2_reg, product_hist2_next;
    logic signed [SW-1:0] output_hist1_reg, output_hist1_next;
    logic signed [SW-1:0] output_hist2_reg, output_hist2_next;
    logic                 out_valid_reg, out_valid_next;
    logic signed [SW-1:0] out_mixed_reg, out_mixed_next;
    logic signed [SW-1:0] out_filt_reg, out_filt_next;
    logic                 out_load;
    logic                 accept;

    // shared unit
    mbl_mac_ctrl_t          mac_ctrl;
    logic signed [OPA_W-1:0]  opa;
    logic signed [SW-1:0]     opb;
    logic signed [PROD_W-1:0] mul_q;
    logic signed [ACC_W-1:0]  acc_q;

    // saturation
    logic signed [PROD_W-1:0] mix_sh;
    logic [PROD_W-SW:0]       mix_top;
    logic signed [SW-1:0]     p_sat;
    logic signed [Y_W-1:0]    acc_x;
    logic signed [Y_W-1:0]    y_sh;
    logic [Y_W-SW:0]          y_top;
    logic signed [SW-1:0]     y_sat;

    // ---------------------------------------------------------------- APB
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = mbl_reg_idx_t'(paddr[ADDR_W-1:STRIDE_LOG]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg <= '0;
            coef_b1_reg <= '0;
            coef_b2_reg <= '0;
            coef_a1_reg <= '0;
            coef_a2_reg <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_B0:  coef_b0_reg <= signed'(pwdata[CW-1:0]);
                REG_B1:  coef_b1_reg <= signed'(pwdata[CW-1:0]);
                REG_B2:  coef_b2_reg <= signed'(pwdata[CW-1:0]);
                REG_A1:  coef_a1_reg <= signed'(pwdata[CW-1:0]);
                REG_A2:  coef_a2_reg <= signed'(pwdata[CW-1:0]);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_B0:  prdata = DATA_W'(coef_b0_reg);
            REG_B1:  prdata = DATA_W'(coef_b1_reg);
            REG_B2:  prdata = DATA_W'(coef_b2_reg);
            REG_A1:  prdata = DATA_W'(coef_a1_reg);
            REG_A2:  prdata = DATA_W'(coef_a2_reg);
            default: prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- saturation
    assign mix_sh  = mul_q >>> (SW - 1);
    assign mix_top = mix_sh[PROD_W-1:SW-1];
    assign p_sat   = ((&mix_top) || !(|mix_top)) ? mix_sh[SW-1:0]
                   : {mix_sh[PROD_W-1], {(SW-1){~mix_sh[PROD_W-1]}}};

    assign acc_x = Y_W'(acc_q);
    assign y_sh  = acc_x >>> COEF_FRAC;
    assign y_top = y_sh[Y_W-1:SW-1];
    assign y_sat = ((&y_top) || !(|y_top)) ? y_sh[SW-1:0]
                 : {y_sh[Y_W-1], {(SW-1){~y_sh[Y_W-1]}}};

    // ---------------------------------------------------------------- sequencer
    assign accept = sample_ch.valid && sample_ch.ready;

    always_comb
    begin
        state_next         = state_reg;
        p_next             = p_reg;
        product_hist1_next = product_hist1_reg;
        product_hist2_next = product_hist2_reg;
        output_hist1_next  = output_hist1_reg;
        output_hist2_next  = output_hist2_reg;
        out_mixed_next     = out_mixed_reg;
        out_filt_next      = out_filt_reg;
        out_load           = 1'b0;
        mac_ctrl.mul_en    = 1'b1;
        mac_ctrl.acc_op    = ACC_HOLD;
        opa                = OPA_W'(sample_ch.signal_sample);
        opb                = sample_ch.reference_sample;

        unique case (state_reg)
            S_IDLE:
            begin
                mac_ctrl.mul_en = accept;
                if (accept)
                begin
                    state_next = S_SAT;
                end
            end
            S_SAT:
            begin
                p_next     = p_sat;
                opa        = OPA_W'(coef_b1_reg);
                opb        = product_hist1_reg;
                state_next = S_B2;
            end
            S_B2:
            begin
                opa             = OPA_W'(coef_b2_reg);
                opb             = product_hist2_reg;
                mac_ctrl.acc_op = ACC_LOAD;
                state_next      = S_A1;
            end
            S_A1:
            begin
                opa             = OPA_W'(coef_a1_reg);
                opb             = output_hist1_reg;
                mac_ctrl.acc_op = ACC_ADD;
                state_next      = S_A2;
            end
            S_A2:
            begin
                opa             = OPA_W'(coef_a2_reg);
                opb             = output_hist2_reg;
                mac_ctrl.acc_op = ACC_SUB;
                state_next      = S_B0;
            end
            S_B0:
            begin
                opa             = OPA_W'(coef_b0_reg);
                opb             = p_reg;
                mac_ctrl.acc_op = ACC_SUB;
                state_next      = S_ADD;
            end
            S_ADD:
            begin
                mac_ctrl.mul_en = 1'b0;
                mac_ctrl.acc_op = ACC_ADD;
                state_next      = S_OUT;
            end
            S_OUT:
            begin
                mac_ctrl.mul_en = 1'b0;
                // hold until the output register frees
                if (!out_valid_reg || result_ch.ready)
                begin
                    out_load           = 1'b1;
                    out_mixed_next     = p_reg;
                    out_filt_next      = y_sat;
                    product_hist2_next = product_hist1_reg;
                    product_hist1_next = p_reg;
                    output_hist2_next  = output_hist1_reg;
                    output_hist1_next  = y_sat;
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            out_valid_reg     <= 1'b0;
            product_hist1_reg <= '0;
            product_hist2_reg <= '0;
            output_hist1_reg  <= '0;
            output_hist2_reg  <= '0;
            p_reg             <= '0;
            out_mixed_reg     <= '0;
            out_filt_reg      <= '0;
        end
        else
        begin
            state_reg         <= state_next;
            out_valid_reg     <= out_valid_next;
            product_hist1_reg <= product_hist1_next;
            product_hist2_reg <= product_hist2_next;
            output_hist1_reg  <= output_hist1_next;
            output_hist2_reg  <= output_hist2_next;
            p_reg             <= p_next;
            out_mixed_reg     <= out_mixed_next;
            out_filt_reg      <= out_filt_next;
        end
    end

    mbl_mac #(
        .OPA_W   (OPA_W),
        .OPB_W   (SW),
        .ACC_W   (ACC_W),
        .RND_POS (COEF_FRAC - 1)
    ) u_mac (
        .clk   (clk),
        .ctrl  (mac_ctrl),
        .opa   (opa),
        .opb   (opb),
        .mul_q (mul_q),
        .acc_q (acc_q)
    );

    assign sample_ch.ready           = (state_reg == S_IDLE);
    assign result_ch.valid           = out_valid_reg;
    assign result_ch.mixed_product   = out_mixed_reg;
    assign result_ch.filtered_sample = out_filt_reg;

    // ---------------------------------------------------------------- checks
    `ASSERT_NEXT(a_accept_starts_seq, clk, rst_n, accept, state_reg == S_SAT)
    `ASSERT_NEXT(a_load_shows_result, clk, rst_n, out_load, result_ch.valid && state_reg == S_IDLE)
    `ASSERT_NEXT(a_hist_shift, clk, rst_n, out_load, product_hist2_reg == $past(product_hist1_reg) && output_hist1_reg == result_ch.filtered_sample)
    `ASSERT_NEXT(a_stall_holds_seq, clk, rst_n, state_reg == S_OUT && out_valid_reg && !result_ch.ready, state_reg == S_OUT)

endmodule

// ===== sim/mixer_biquad_lowpass_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for mixer_biquad_lowpass: drives sample items and APB
// coefficient writes, predicts the mixer and biquad results and compares them.
// Depends on mbl_pkg, mbl_ifs and the mixer_biquad_lowpass RTL.
module mixer_biquad_lowpass_tb;
    import mbl_pkg::*;

    localparam int RANDOM_PHASES    = 11;
    localparam int ITEMS_PER_PHASE  = 140;
    localparam int DRAIN_LIMIT      = 4000;
    localparam longint RUN_LIMIT_NS = 5_000_000;

    localparam logic signed [31:0] LOWPASS_COEFS [NUM_REGS] = '{
        32'sd10782010, 32'sd21564020, 32'sd10782010, -32'sd838065211, 32'sd344322965
    };

    typedef struct packed {
        logic signed [15:0] mixed;
        logic signed [15:0] filtered;
    } filter_result_t;

    typedef enum {ROW_ITEM, ROW_COEF} row_kind_t;

    typedef enum {COEFS_LOWPASS, COEFS_WIDE, COEFS_UNITY_RANGE, COEFS_EXTREME} coef_style_t;

    typedef struct {
        row_kind_t          kind;
        logic signed [15:0] signal_in;
        logic signed [15:0] reference_in;
        bit                 typed;
        filter_result_t     result;
        int                 reg_sel;
        logic [31:0]        value;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mbl_in_if  #(.SAMPLE_WIDTH(16)) sample_ch ();
    mbl_out_if #(.SAMPLE_WIDTH(16)) result_ch ();

    mixer_biquad_lowpass #(
        .SAMPLE_WIDTH(16),
        .COEF_WIDTH  (32)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .sample_ch(sample_ch),
        .result_ch(result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    logic signed [31:0] coef [NUM_REGS];
    logic signed [15:0] prod_hist1;
    logic signed [15:0] prod_hist2;
    logic signed [15:0] out_hist1;
    logic signed [15:0] out_hist2;

    filter_result_t pending_filter_results [$];
    filter_result_t oldest_result;
    stim_row_t      directed_rows [$];
    int             mismatch_count;
    bit             idle_on;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                   input logic signed [31:0] want);
        $display("%0t ns %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [15:0] clamp_q15(input longint v);
        if (v > 32767)
            return 16'sh7FFF;
        else if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic filter_result_t mix_and_filter(input logic signed [15:0] s,
                                                      input logic signed [15:0] r);
        longint         prod;
        longint         acc;
        filter_result_t res;
        prod = longint'(s) * longint'(r);
        res.mixed = clamp_q15(prod >>> 15);
        acc = longint'(coef[REG_B0]) * longint'(res.mixed)
            + longint'(coef[REG_B1]) * longint'(prod_hist1)
            + longint'(coef[REG_B2]) * longint'(prod_hist2)
            - longint'(coef[REG_A1]) * longint'(out_hist1)
            - longint'(coef[REG_A2]) * longint'(out_hist2);
        acc = acc + (longint'(1) <<< 28);
        res.filtered = clamp_q15(acc >>> 29);
        prod_hist2 = prod_hist1;
        prod_hist1 = res.mixed;
        out_hist2  = out_hist1;
        out_hist1  = res.filtered;
        return res;
    endfunction

    function automatic void add_item(input logic signed [15:0] s, input logic signed [15:0] r,
                                     input bit typed, input logic signed [15:0] mixed,
                                     input logic signed [15:0] filtered);
        stim_row_t row;
        row.kind            = ROW_ITEM;
        row.signal_in       = s;
        row.reference_in    = r;
        row.typed           = typed;
        row.result.mixed    = mixed;
        row.result.filtered = filtered;
        row.reg_sel         = 0;
        row.value           = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_coef(input int reg_sel, input logic [31:0] value);
        stim_row_t row;
        row.kind         = ROW_COEF;
        row.signal_in    = '0;
        row.reference_in = '0;
        row.typed        = 1'b0;
        row.result       = '0;
        row.reg_sel      = reg_sel;
        row.value        = value;
        directed_rows.push_back(row);
    endfunction

    function automatic logic signed [15:0] random_q15();
        logic signed [15:0] v;
        case ($urandom_range(0, 9))
            0: v = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
            1: v = 16'($urandom_range(0, 64)) - 16'sd32;
            default: v = 16'($urandom);
        endcase
        return v;
    endfunction

    function automatic logic [31:0] coef_value(input coef_style_t style, input int idx);
        logic [31:0] v;
        case (style)
            COEFS_LOWPASS: v = LOWPASS_COEFS[idx];
            COEFS_WIDE: v = $urandom;
            COEFS_UNITY_RANGE: v = 32'($urandom_range(0, 32'h4000_0000)) - 32'h2000_0000;
            default:
            begin
                case ($urandom_range(0, 2))
                    0: v = 32'h7FFF_FFFF;
                    1: v = 32'h8000_0000;
                    default: v = '0;
                endcase
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic signed [15:0] s, input logic signed [15:0] r,
                             input bit typed, input filter_result_t typed_result);
        filter_result_t predicted;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        sample_ch.valid            <= 1'b1;
        sample_ch.signal_sample    <= s;
        sample_ch.reference_sample <= r;
        do @(posedge clk); while (!sample_ch.ready);
        predicted = mix_and_filter(s, r);
        pending_filter_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic drain();
        @(negedge clk);
        sample_ch.valid <= 1'b0;
        while (pending_filter_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic apb_access(input bit is_write, input int idx, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= 5'(idx * 4);
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_coef(input int idx, input logic [31:0] value);
        logic [31:0] rdata;
        drain();
        apb_access(1'b1, idx, value, rdata);
        if (idx < NUM_REGS)
        begin
            coef[idx] = value;
            apb_access(1'b0, idx, '0, rdata);
            if (rdata !== coef[idx])
                report_mismatch("coefficient readback", rdata, coef[idx]);
        end
    endtask

    initial
    begin
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (idle_on && $urandom_range(0, 3) == 0)
            begin
                @(negedge clk);
                result_ch.ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            @(negedge clk);
            result_ch.ready <= 1'b1;
            repeat ($urandom_range(0, 6)) @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_filter_results.size() == 0)
                report_mismatch("result with no item outstanding", result_ch.filtered_sample, 0);
            else
            begin
                oldest_result = pending_filter_results.pop_front();
                if (result_ch.mixed_product !== oldest_result.mixed)
                    report_mismatch("mixed_product", result_ch.mixed_product,
                                    oldest_result.mixed);
                if (result_ch.filtered_sample !== oldest_result.filtered)
                    report_mismatch("filtered_sample", result_ch.filtered_sample,
                                    oldest_result.filtered);
            end
        end
    end

    initial
    begin
        int          phase;
        int          n;
        int          wait_cycles;
        coef_style_t style;

        rst_n                      = 1'b0;
        sample_ch.valid            = 1'b0;
        sample_ch.signal_sample    = '0;
        sample_ch.reference_sample = '0;
        psel                       = 1'b0;
        penable                    = 1'b0;
        pwrite                     = 1'b0;
        paddr                      = '0;
        pwdata                     = '0;
        idle_on                    = 1'b1;
        mismatch_count             = 0;
        prod_hist1                 = '0;
        prod_hist2                 = '0;
        out_hist1                  = '0;
        out_hist2                  = '0;
        foreach (coef[i])
            coef[i] = '0;

        // zero coefficients after reset: filtered output stays zero
        add_item(16'sd0, 16'sd0, 1'b1, 16'sd0, 16'sd0);
        add_item(16'sd32767, 16'sd32767, 1'b1, 16'sd32766, 16'sd0);
        add_item(-16'sd32768, -16'sd32768, 1'b1, 16'sd32767, 16'sd0);
        add_item(-16'sd32768, 16'sd32767, 1'b1, -16'sd32767, 16'sd0);
        add_item(-16'sd1, 16'sd1, 1'b1, -16'sd1, 16'sd0);
        add_item(16'sd1, 16'sd1, 1'b1, 16'sd0, 16'sd0);
        // largest gains drive the output into saturation
        add_coef(REG_B0, 32'h7FFF_FFFF);
        add_item(16'sd32767, 16'sd32767, 1'b1, 16'sd32766, 16'sd32767);
        add_item(16'sd32767, -16'sd32768, 1'b1, -16'sd32767, -16'sd32768);
        add_coef(REG_B0, 32'h8000_0000);
        add_item(16'sd32767, 16'sd32767, 1'b1, 16'sd32766, -16'sd32768);
        add_item(-16'sd32768, 16'sd32767, 1'b1, -16'sd32767, 16'sd32767);
        add_coef(REG_B0, 32'h2000_0000);
        add_coef(REG_B1, 32'h7FFF_FFFF);
        add_coef(REG_B2, 32'h8000_0000);
        add_coef(REG_A1, 32'h7FFF_FFFF);
        add_coef(REG_A2, 32'h8000_0000);
        add_coef(NUM_REGS, 32'h1234_5678);
        add_coef(NUM_REGS + 2, 32'hFFFF_FFFF);
        add_item(16'sd16384, 16'sd16384, 1'b0, '0, '0);
        add_item(-16'sd32768, -16'sd32768, 1'b0, '0, '0);
        add_item(16'sd12345, -16'sd23456, 1'b0, '0, '0);
        add_item(16'sd0, 16'sd0, 1'b0, '0, '0);
        add_item(16'sd0, 16'sd0, 1'b0, '0, '0);
        add_item(-16'sd32768, 16'sd32767, 1'b0, '0, '0);
        for (int i = 0; i < NUM_REGS; i++)
            add_coef(i, LOWPASS_COEFS[i]);
        add_item(16'sd20000, 16'sd30000, 1'b0, '0, '0);
        add_item(-16'sd20000, 16'sd30000, 1'b0, '0, '0);
        add_item(16'sd5, -16'sd7, 1'b0, '0, '0);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_ITEM)
                send_item(directed_rows[i].signal_in, directed_rows[i].reference_in,
                          directed_rows[i].typed, directed_rows[i].result);
            else
                set_coef(directed_rows[i].reg_sel, directed_rows[i].value);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = (phase != 3) && (phase < RANDOM_PHASES - 1);
            style = (phase == 0) ? COEFS_LOWPASS : coef_style_t'($urandom_range(0, 3));
            for (int i = 0; i < NUM_REGS; i++)
                set_coef(i, coef_value(style, i));
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 5 && n == ITEMS_PER_PHASE / 2)
                    drain();
                send_item(random_q15(), random_q15(), 1'b0, '0);
            end
        end

        @(negedge clk);
        sample_ch.valid <= 1'b0;
        wait_cycles = 0;
        while (pending_filter_results.size() != 0 && wait_cycles < DRAIN_LIMIT)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (16) @(posedge clk);
        if (pending_filter_results.size() != 0)
            report_mismatch("results never returned", pending_filter_results.size(), 0);

        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
